// ----- rtl/core/lbc_pkg.sv -----
`timescale 1ns / 1ps

package lbc_pkg;

    localparam int DEV_W     = 16;
    localparam int BLK_W     = 32;
    localparam int TAG_W     = DEV_W + BLK_W;
    localparam int HOLD_W    = 8;
    localparam int SLOT_IN_W = 5;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_UNHELD   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

endpackage

// ----- rtl/core/lbc_order.sv -----
`timescale 1ns / 1ps

// Recency list: position -> slot. Position 0 is most recent.
// Unwritten positions read as their reset value, SLOT_COUNT-1-pos.
module lbc_order #(
    parameter int SLOT_COUNT = 32,
    parameter int SLOT_W     = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_pos,
    output logic [SLOT_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_pos,
    input  logic [SLOT_W-1:0] wr_data
);

    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(SLOT_COUNT - 1);

    logic [SLOT_W-1:0]     order_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    logic [SLOT_W-1:0]     rd_mem_reg;
    logic                  rd_vld_reg;
    logic [SLOT_W-1:0]     rd_pos_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            order_mem[wr_pos] <= wr_data;
        end
        rd_mem_reg <= order_mem[rd_pos];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_pos_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_pos] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_pos];
            rd_pos_reg <= rd_pos;
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : (LAST_POS - rd_pos_reg);

endmodule

// ----- rtl/core/lru_block_buffer_cache.sv -----
// Block buffer cache, SLOT_COUNT slots, LRU reuse. One word in flight at a time.
// Acquire: hit scan MRU->LRU comparing tags; on a miss, a free scan LRU->MRU for
// a count of zero (one position per cycle, 2-stage read). Release: read and
// decrement the count; when it drops to zero, find the slot in the recency list,
// shift the more recent positions down by one and put the slot at position 0.
// Reset: async, tags/counts/valid/recency restored at once by valid bits, no sweep.
`timescale 1ns / 1ps

module lru_block_buffer_cache
    import lbc_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [DEV_W-1:0]     device,
    input  logic [BLK_W-1:0]     block_number,
    input  logic [SLOT_IN_W-1:0] slot,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SLOT_IN_W-1:0] slot_out,
    output logic                 needs_read,
    output logic [1:0]           status
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(SLOT_COUNT);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_HIT,   // walk recency list MRU->LRU, compare tags
        S_SCAN_FREE,  // walk LRU->MRU, look for count zero
        S_REL_RD,     // read hold count of released slot
        S_REL_CHK,    // decrement, decide on move to front
        S_FIND,       // locate released slot in recency list
        S_SH_RD,      // shift step: read position sp-1
        S_SH_WR,      // shift step: write it to position sp
        S_FRONT,      // put released slot at position 0
        S_OUT         // hand result to output register
    } state_t;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   s1_vld_reg, s1_vld_next;
    logic                   s1_last_reg, s1_last_next;
    logic [SLOT_W-1:0]      s1_pos_reg, s1_pos_next;
    logic                   s2_vld_reg, s2_vld_next;
    logic                   s2_last_reg, s2_last_next;
    logic [SLOT_W-1:0]      s2_slot_reg, s2_slot_next;
    logic [DEV_W-1:0]       req_dev_reg, req_dev_next;
    logic [BLK_W-1:0]       req_blk_reg, req_blk_next;
    logic [SLOT_IN_W-1:0]   req_slot_reg, req_slot_next;
    logic [SLOT_W-1:0]      sp_reg, sp_next;
    logic [SLOT_IN_W-1:0]   res_slot_reg, res_slot_next;
    logic                   res_read_reg, res_read_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SLOT_IN_W-1:0]   slot_out_reg, slot_out_next;
    logic                   needs_read_reg, needs_read_next;
    status_t                status_reg, status_next;

    // per-slot valid bits: tag written, count written, data valid
    logic [SLOT_COUNT-1:0]  tag_vld_reg;
    logic [SLOT_COUNT-1:0]  hold_vld_reg;
    logic [SLOT_COUNT-1:0]  dvalid_reg;
    logic                   tag_rv_reg;
    logic                   hold_rv_reg;

    // tag and hold count memories, one read and one write port each
    logic [TAG_W-1:0]       tag_mem  [SLOT_COUNT];
    logic [HOLD_W-1:0]      hold_mem [SLOT_COUNT];
    logic [TAG_W-1:0]       tag_rd_reg;
    logic [HOLD_W-1:0]      hold_rd_reg;

    // ---------------------------------------------------------------
    // Datapath signals
    // ---------------------------------------------------------------
    logic                   issuing;
    logic [SLOT_W-1:0]      issue_pos;
    logic [SLOT_W-1:0]      order_rd_pos;
    logic [SLOT_W-1:0]      order_rd;
    logic                   order_we;
    logic [SLOT_W-1:0]      order_wpos;
    logic [SLOT_W-1:0]      order_wd;
    logic [SLOT_W-1:0]      rel_idx;
    logic [SLOT_W-1:0]      rd_slot;
    logic [SLOT_W-1:0]      wr_slot;
    logic [TAG_W-1:0]       tag_rd;
    logic [HOLD_W-1:0]      hold_rd;
    logic                   dv_cur;
    logic                   tag_we;
    logic                   hold_we;
    logic [HOLD_W-1:0]      hold_wd;
    logic                   dv_set;
    logic [TAG_W-1:0]       cmp_a;
    logic [TAG_W-1:0]       cmp_b;
    logic                   cmp_eq;

    assign rel_idx = SLOT_W'(req_slot_reg);

    // Scan issue: one recency position per cycle. The free scan walks from
    // the least recent end, the hit and find scans from the most recent.
    assign issuing = ((state_reg == S_SCAN_HIT) || (state_reg == S_SCAN_FREE) ||
                      (state_reg == S_FIND)) && (cnt_reg != CNT_END);
    assign issue_pos = (state_reg == S_SCAN_FREE) ? (LAST_POS - cnt_reg[SLOT_W-1:0])
                                                  : cnt_reg[SLOT_W-1:0];
    assign order_rd_pos = (state_reg == S_SH_RD) ? (sp_reg - SLOT_W'(1)) : issue_pos;

    lbc_order #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_order (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_pos  (order_rd_pos),
        .rd_data (order_rd),
        .wr_en   (order_we),
        .wr_pos  (order_wpos),
        .wr_data (order_wd)
    );

    // Second stage reads tag and count of the slot found at the position
    // read in the previous cycle; a release reads its own slot directly.
    assign rd_slot = (state_reg == S_REL_RD) ? rel_idx : order_rd;
    assign wr_slot = (state_reg == S_REL_CHK) ? rel_idx : s2_slot_reg;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_slot] <= {req_dev_reg, req_blk_reg};
        end
        if (hold_we)
        begin
            hold_mem[wr_slot] <= hold_wd;
        end
        tag_rd_reg  <= tag_mem[rd_slot];
        hold_rd_reg <= hold_mem[rd_slot];
    end

    // never-written entries read as zero
    assign tag_rd  = tag_rv_reg  ? tag_rd_reg  : '0;
    assign hold_rd = hold_rv_reg ? hold_rd_reg : '0;
    assign dv_cur  = dvalid_reg[s2_slot_reg];

    // Shared equality unit: tag match, count-is-zero, or slot-in-list.
    always_comb
    begin
        case (state_reg)
            S_SCAN_HIT:
            begin
                cmp_a = {req_dev_reg, req_blk_reg};
                cmp_b = tag_rd;
            end
            S_SCAN_FREE:
            begin
                cmp_a = '0;
                cmp_b = TAG_W'(hold_rd);
            end
            S_FIND:
            begin
                cmp_a = TAG_W'(rel_idx);
                cmp_b = TAG_W'(order_rd);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = issuing ? (cnt_reg + CNT_W'(1)) : cnt_reg;
        s1_vld_next     = issuing;
        s1_last_next    = (cnt_reg == CNT_LAST);
        s1_pos_next     = issue_pos;
        s2_vld_next     = s1_vld_reg &&
                          ((state_reg == S_SCAN_HIT) || (state_reg == S_SCAN_FREE));
        s2_last_next    = s1_last_reg;
        s2_slot_next    = order_rd;
        req_dev_next    = req_dev_reg;
        req_blk_next    = req_blk_reg;
        req_slot_next   = req_slot_reg;
        sp_next         = sp_reg;
        res_slot_next   = res_slot_reg;
        res_read_next   = res_read_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        slot_out_next   = slot_out_reg;
        needs_read_next = needs_read_reg;
        status_next     = status_reg;
        tag_we          = 1'b0;
        hold_we         = 1'b0;
        hold_wd         = '0;
        dv_set          = 1'b0;
        order_we        = 1'b0;
        order_wpos      = sp_reg;
        order_wd        = order_rd;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_dev_next    = device;
                    req_blk_next    = block_number;
                    req_slot_next   = slot;
                    cnt_next        = '0;
                    res_read_next   = 1'b0;
                    res_status_next = ST_OK;
                    if (kind == KIND_ACQUIRE)
                    begin
                        state_next = S_SCAN_HIT;
                    end
                    else
                    begin
                        res_slot_next = slot;
                        if (int'(slot) >= SLOT_COUNT)
                        begin
                            res_status_next = ST_UNHELD;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_REL_RD;
                        end
                    end
                end
            end

            S_SCAN_HIT:
            begin
                if (s2_vld_reg && cmp_eq)
                begin
                    res_slot_next = SLOT_IN_W'(s2_slot_reg);
                    if (hold_rd == HOLD_MAX)
                    begin
                        res_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        hold_we       = 1'b1;
                        hold_wd       = hold_rd + HOLD_W'(1);
                        dv_set        = 1'b1;
                        res_read_next = !dv_cur;
                    end
                    s1_vld_next = 1'b0;
                    s2_vld_next = 1'b0;
                    state_next  = S_OUT;
                end
                else if (s2_vld_reg && s2_last_reg)
                begin
                    cnt_next    = '0;
                    s1_vld_next = 1'b0;
                    s2_vld_next = 1'b0;
                    state_next  = S_SCAN_FREE;
                end
            end

            S_SCAN_FREE:
            begin
                if (s2_vld_reg && cmp_eq)
                begin
                    tag_we        = 1'b1;
                    hold_we       = 1'b1;
                    hold_wd       = HOLD_W'(1);
                    dv_set        = 1'b1;
                    res_slot_next = SLOT_IN_W'(s2_slot_reg);
                    res_read_next = 1'b1;
                    s1_vld_next   = 1'b0;
                    s2_vld_next   = 1'b0;
                    state_next    = S_OUT;
                end
                else if (s2_vld_reg && s2_last_reg)
                begin
                    res_slot_next   = '0;
                    res_status_next = ST_NO_FREE;
                    state_next      = S_OUT;
                end
            end

            S_REL_RD:
            begin
                state_next = S_REL_CHK;
            end

            S_REL_CHK:
            begin
                if (hold_rd == '0)
                begin
                    res_status_next = ST_UNHELD;
                    state_next      = S_OUT;
                end
                else
                begin
                    hold_we = 1'b1;
                    hold_wd = hold_rd - HOLD_W'(1);
                    if (hold_rd == HOLD_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = S_FIND;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_FIND:
            begin
                if (s1_vld_reg && cmp_eq)
                begin
                    s1_vld_next = 1'b0;
                    sp_next     = s1_pos_reg;
                    if (s1_pos_reg == '0)
                    begin
                        state_next = S_FRONT;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (s1_vld_reg && s1_last_reg)
                begin
                    state_next = S_OUT;
                end
            end

            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                order_we   = 1'b1;
                order_wpos = sp_reg;
                order_wd   = order_rd;
                sp_next    = sp_reg - SLOT_W'(1);
                if (sp_reg == SLOT_W'(1))
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end

            S_FRONT:
            begin
                order_we   = 1'b1;
                order_wpos = '0;
                order_wd   = rel_idx;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    slot_out_next   = res_slot_reg;
                    needs_read_next = res_read_reg;
                    status_next     = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            s1_vld_reg     <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_pos_reg     <= '0;
            s2_vld_reg     <= 1'b0;
            s2_last_reg    <= 1'b0;
            s2_slot_reg    <= '0;
            req_dev_reg    <= '0;
            req_blk_reg    <= '0;
            req_slot_reg   <= '0;
            sp_reg         <= '0;
            res_slot_reg   <= '0;
            res_read_reg   <= 1'b0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            slot_out_reg   <= '0;
            needs_read_reg <= 1'b0;
            status_reg     <= ST_OK;
            tag_vld_reg    <= '0;
            hold_vld_reg   <= '0;
            dvalid_reg     <= '0;
            tag_rv_reg     <= 1'b0;
            hold_rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            s1_vld_reg     <= s1_vld_next;
            s1_last_reg    <= s1_last_next;
            s1_pos_reg     <= s1_pos_next;
            s2_vld_reg     <= s2_vld_next;
            s2_last_reg    <= s2_last_next;
            s2_slot_reg    <= s2_slot_next;
            req_dev_reg    <= req_dev_next;
            req_blk_reg    <= req_blk_next;
            req_slot_reg   <= req_slot_next;
            sp_reg         <= sp_next;
            res_slot_reg   <= res_slot_next;
            res_read_reg   <= res_read_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            slot_out_reg   <= slot_out_next;
            needs_read_reg <= needs_read_next;
            status_reg     <= status_next;
            if (tag_we)
            begin
                tag_vld_reg[wr_slot] <= 1'b1;
            end
            if (hold_we)
            begin
                hold_vld_reg[wr_slot] <= 1'b1;
            end
            if (dv_set)
            begin
                dvalid_reg[s2_slot_reg] <= 1'b1;
            end
            tag_rv_reg  <= tag_vld_reg[rd_slot];
            hold_rv_reg <= hold_vld_reg[rd_slot];
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign slot_out   = slot_out_reg;
    assign needs_read = needs_read_reg;
    assign status     = status_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // tag compare stage is only fed from the recency read stage
    a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("tag stage valid without preceding order stage");

    // a retag always takes the slot with count one and data marked valid
    a_retag: assert property (@(posedge clk) disable iff (!rst_n)
        tag_we |-> (hold_we && dv_set && (hold_wd == HOLD_W'(1))))
        else $error("retag without hold count and valid update");

    // recency search only follows a release that dropped the count to zero
    a_find_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) && ($past(state_reg) != S_FIND)
            |-> ($past(state_reg) == S_REL_CHK) && ($past(hold_rd) == HOLD_W'(1)))
        else $error("recency search entered without final release");

    // no free slot reports slot zero and no read
    a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_FREE) |-> (slot_out == '0) && !needs_read)
        else $error("no-free result carries slot or read flag");

endmodule
